[src/chunk_linear_fade_ramp_assert.svh]
// Assertion macros for the chunk fade ramp block.
// Included by the top level; needs nothing else.
`ifndef CHUNK_LINEAR_FADE_RAMP_ASSERT_SVH
`define CHUNK_LINEAR_FADE_RAMP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fade ramp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fade ramp: next-cycle check failed");

`endif

[src/cfl_pkg.sv]
// Shared types and constants of the chunk fade ramp block.
// No dependencies; used by the interfaces and every module.
package cfl_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int RATE_W     = 19;
	localparam int CHAN_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int RAMP_W     = 12;
	localparam int RS_W       = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd2;

	// rate/200 is (rate/8)/25; floor(x*RECIP_25 >> RECIP_SHIFT) is exact for x < 2^16
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 21;
	localparam logic [RECIP_W-1:0] RECIP_25 = 17'd83887;
	localparam int RECIP_PROD_W = RATE_W - 3 + RECIP_W;

	// derived configuration takes three register stages to settle
	localparam logic [1:0] CFG_SETTLE = 2'd3;

	localparam int DIV_NUM_W = 28;
	localparam int DIV_DEN_W = 13;
	localparam int DIV_Q_W   = 16;
	localparam int DIV_CNT_W = 4;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} cfl_div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quot;
	} cfl_div_rsp_t;

	typedef struct packed {
		logic settled;
		logic total_nz;
		logic scale_ok;
	} cfl_cfg_flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DIV_K,
		ST_MUL,
		ST_Q_GO,
		ST_DIV_Q,
		ST_EMIT
	} cfl_state_t;

endpackage

[src/cfl_stream_if.sv]
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on cfl_pkg for field widths.
interface cfl_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [cfl_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface cfl_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [cfl_pkg::SAMPLE_W-1:0] sample_out;
	logic                          chunk_end;

	modport source (output valid, output sample_out, output chunk_end, input ready);
	modport sink   (input valid, input sample_out, input chunk_end, output ready);
endinterface

interface cfl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cfl_pkg::CFG_IDX_W-1:0]   index;
	logic [cfl_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/cfl_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on cfl_pkg; quotient must be known to fit in DIV_Q_W bits.
module cfl_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfl_pkg::cfl_div_req_t req,
	output cfl_pkg::cfl_div_rsp_t rsp
);
	import cfl_pkg::*;

	logic [DIV_NUM_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] dsh_q;
	logic [DIV_Q_W-1:0]   quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 fits;
	logic [DIV_NUM_W-1:0] rem_next;

	always_comb begin
		fits     = rem_q >= dsh_q;
		rem_next = rem_q - dsh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			dsh_q  <= DIV_NUM_W'(req.den) << (DIV_Q_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_next;
			end
			quot_q <= {quot_q[DIV_Q_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

[src/cfl_seq.sv]
// Per-sample sequencer: position tracking, ramp classification, two divides
// on the shared unit, one multiply and the output register. Depends on cfl_pkg.
module cfl_seq #(
	parameter int POS_W = 27,
	parameter int CH_W  = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	cfl_in_if.sink                   sample_chan,
	cfl_out_if.source                result_chan,
	input  cfl_pkg::cfl_cfg_flags_t  flags,
	input  logic [POS_W-1:0]         last,
	input  logic [cfl_pkg::RAMP_W-1:0] ramp,
	input  logic [cfl_pkg::RS_W-1:0] ramp_smp,
	input  logic [CH_W-1:0]          eff_ch,
	output cfl_pkg::cfl_div_req_t    div_req,
	input  cfl_pkg::cfl_div_rsp_t    div_rsp
);
	import cfl_pkg::*;

	localparam int CMP_W = (POS_W > RS_W) ? POS_W : RS_W;

	cfl_state_t state_q, state_d;

	logic [POS_W-1:0]           pos_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic                       end_q;
	logic [RAMP_W-1:0]          k_q;
	logic [DIV_NUM_W-1:0]       p_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_end_q;

	logic             at_end, in_range, fade_in, fade_out, do_scale, out_free;
	logic [CMP_W-1:0] pos_x, smp_x, dist_out_x, dist_x;
	logic [SAMPLE_W-1:0] mag;

	// Classification of the current position against the chunk's two ramps
	always_comb begin
		pos_x      = CMP_W'(pos_q);
		smp_x      = CMP_W'(ramp_smp);
		dist_out_x = CMP_W'(last - pos_q);
		at_end     = pos_q >= last;
		in_range   = pos_q <= last;
		fade_in    = pos_x < smp_x;
		fade_out   = dist_out_x < smp_x;
		dist_x     = fade_in ? pos_x : dist_out_x;
		do_scale   = flags.total_nz && in_range && flags.scale_ok && (fade_in || fade_out);
		mag        = sample_q[SAMPLE_W-1] ? SAMPLE_W'(-sample_q) : SAMPLE_W'(sample_q);
		out_free   = !out_valid_q || result_chan.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d           = state_q;
		sample_chan.ready = 1'b0;
		div_req           = '0;
		unique case (state_q)
			ST_IDLE: begin
				sample_chan.ready = flags.settled;
				if (sample_chan.valid && flags.settled) begin
					state_d = ST_CLASS;
				end
			end
			ST_CLASS: begin
				if (do_scale) begin
					div_req.start = 1'b1;
					div_req.num   = DIV_NUM_W'(dist_x[RS_W-1:0]);
					div_req.den   = DIV_DEN_W'(eff_ch);
					state_d       = ST_DIV_K;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV_K: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_Q_GO;
			end
			ST_Q_GO: begin
				// round half away from zero: (2p + ramp) / (2 ramp)
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'({p_q, 1'b0}) + DIV_NUM_W'(ramp);
				div_req.den   = DIV_DEN_W'({ramp, 1'b0});
				state_d       = ST_DIV_Q;
			end
			ST_DIV_Q: begin
				if (div_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLASS) begin
				if (!flags.total_nz || at_end) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_chan.valid && flags.settled) begin
			sample_q <= sample_chan.sample_in;
		end
		if (state_q == ST_CLASS) begin
			end_q <= flags.total_nz && at_end;
			y_q   <= sample_q;
		end
		if (state_q == ST_DIV_K && div_rsp.done) begin
			k_q <= div_rsp.quot[RAMP_W-1:0];
		end
		if (state_q == ST_MUL) begin
			p_q <= DIV_NUM_W'(mag) * DIV_NUM_W'(k_q);
		end
		if (state_q == ST_DIV_Q && div_rsp.done) begin
			y_q <= sample_q[SAMPLE_W-1] ? $signed(-div_rsp.quot) : $signed(div_rsp.quot);
		end
		if (state_q == ST_EMIT && out_free) begin
			out_sample_q <= y_q;
			out_end_q    <= end_q;
		end
	end

	assign result_chan.valid      = out_valid_q;
	assign result_chan.sample_out = out_sample_q;
	assign result_chan.chunk_end  = out_end_q;

endmodule

[src/chunk_linear_fade_ramp.sv]
// Top level of the chunk fade ramp: configuration registers, derived ramp
// values, the sequencer and the shared divider. Depends on cfl_pkg and cfl_stream_if.
//
//  channel      dir   payload                      handshake
//  sample_chan  sink  sample_in (s16)              valid/ready
//  result_chan  src   sample_out (s16), chunk_end  valid/ready
//  cfg_chan     sink  index (2), data (32)         valid/ready, always ready
//
// An unscaled sample goes from acceptance through the classify and emit states into
// the output register; a scaled one also runs the shared divider twice, one quotient
// bit per cycle, a multiply between. The input reopens as the emit state is left.
// Reset clears the position and sets rate 0, one channel and an empty chunk.
// A register write holds the input off while the derived values settle.
// A finished result waits in the output register while the next sample is taken.
module chunk_linear_fade_ramp #(
	parameter int MAX_CHANNELS     = 8,
	parameter int FRAME_COUNT_BITS = 24
) (
	input logic       clk,
	input logic       arst_n,
	cfl_in_if.sink    sample_chan,
	cfl_out_if.source result_chan,
	cfl_cfg_if.sink   cfg_chan
);
	import cfl_pkg::*;

	// Channel count as saturated to MAX_CHANNELS, and the width of a position
	// within a chunk of up to 2^FRAME_COUNT_BITS-1 frames of those channels.
	localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int POS_W = FRAME_COUNT_BITS + $clog2(MAX_CHANNELS);
	localparam int HW    = (FRAME_COUNT_BITS > RAMP_W) ? FRAME_COUNT_BITS : RAMP_W;
	localparam int TOT_W = FRAME_COUNT_BITS + CH_W;

	// Registers as written through the configuration channel.
	logic [RATE_W-1:0]           rate_q;
	logic [CHAN_W-1:0]           chan_q;
	logic [FRAME_COUNT_BITS-1:0] frames_q;
	logic [1:0]                  pend_q;

	// Derived values, settled once the write countdown pend_q reaches zero.
	logic [RAMP_W-1:0] div200_q;
	logic [CH_W-1:0]   eff_q;
	logic [POS_W-1:0]  total_q;
	logic              rate_nz_q;
	logic [RAMP_W-1:0] ramp_q;
	logic [POS_W-1:0]  last_q;
	logic              total_nz_q;
	logic [RS_W-1:0]   ramp_smp_q;

	logic                        cfg_wr;
	logic [RECIP_PROD_W-1:0]     recip_prod;
	logic [CH_W-1:0]             eff_ch;
	logic [TOT_W-1:0]            total_prod;
	logic [FRAME_COUNT_BITS-1:0] half;

	cfl_cfg_flags_t flags;
	cfl_div_req_t   div_req;
	cfl_div_rsp_t   div_rsp;

	assign cfg_chan.ready = 1'b1;
	assign cfg_wr         = cfg_chan.valid && cfg_chan.ready;

	always_comb begin
		// rate * 5 / 1000 is rate / 200, done as a multiply by the reciprocal of 25
		recip_prod = RECIP_PROD_W'(rate_q[RATE_W-1:3]) * RECIP_PROD_W'(RECIP_25);
		// a channel count beyond the build limit is clamped to it
		if ({1'b0, chan_q} > (CHAN_W + 1)'(MAX_CHANNELS)) begin
			eff_ch = CH_W'(MAX_CHANNELS);
		end else begin
			eff_ch = CH_W'(chan_q);
		end
		total_prod = TOT_W'(frames_q) * TOT_W'(eff_ch);
		half       = frames_q >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= '0;
			chan_q     <= CHAN_W'(1);
			frames_q   <= '0;
			pend_q     <= '0;
			div200_q   <= '0;
			eff_q      <= CH_W'(1);
			total_q    <= '0;
			rate_nz_q  <= 1'b0;
			ramp_q     <= '0;
			last_q     <= '0;
			total_nz_q <= 1'b0;
			ramp_smp_q <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_chan.index)
					REG_RATE:   rate_q   <= cfg_chan.data[RATE_W-1:0];
					REG_CHAN:   chan_q   <= cfg_chan.data[CHAN_W-1:0];
					REG_FRAMES: frames_q <= cfg_chan.data[FRAME_COUNT_BITS-1:0];
					default: begin
					end
				endcase
				pend_q <= CFG_SETTLE;
			end else if (pend_q != '0) begin
				pend_q <= pend_q - 1'b1;
			end

			// first stage: straight from the registers
			div200_q  <= recip_prod[RECIP_SHIFT +: RAMP_W];
			eff_q     <= eff_ch;
			total_q   <= total_prod[POS_W-1:0];
			rate_nz_q <= rate_q != '0;

			// second stage: ramp capped at half the chunk, last sample index
			if (HW'(div200_q) < HW'(half)) begin
				ramp_q <= div200_q;
			end else begin
				ramp_q <= RAMP_W'(half);
			end
			last_q     <= total_q - 1'b1;
			total_nz_q <= total_q != '0;

			// third stage: ramp span in samples
			ramp_smp_q <= RS_W'(ramp_q) * RS_W'(eff_q);
		end
	end

	assign flags.settled  = pend_q == '0;
	assign flags.total_nz = total_nz_q;
	assign flags.scale_ok = rate_nz_q && (ramp_q != '0);

	cfl_seq #(
		.POS_W(POS_W),
		.CH_W (CH_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_chan(sample_chan),
		.result_chan(result_chan),
		.flags      (flags),
		.last       (last_q),
		.ramp       (ramp_q),
		.ramp_smp   (ramp_smp_q),
		.eff_ch     (eff_q),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	cfl_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// While derived values settle no sample may enter.
	`include "chunk_linear_fade_ramp_assert.svh"
	`CFL_ASSERT_IMPL(a_settle_blocks_input, clk, arst_n, pend_q != '0, !sample_chan.ready)
	// Only one sample is in flight: the cycle after an accept the input is closed.
	`CFL_ASSERT_NEXT(a_one_sample, clk, arst_n, sample_chan.valid && sample_chan.ready, !sample_chan.ready)
	// Once settled the ramp never exceeds half the chunk.
	`CFL_ASSERT_IMPL(a_ramp_capped, clk, arst_n, pend_q == '0, HW'(ramp_q) <= HW'(half))

endmodule

[tb/chunk_linear_fade_ramp_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the chunk fade ramp: directed table, then random phases.
// Depends on cfl_pkg, the cfl_stream_if interfaces and the chunk_linear_fade_ramp top level.
module chunk_linear_fade_ramp_test;
	import cfl_pkg::*;

	// Block parameters, kept in step with the instance below.
	localparam int FADE_MAX_CHANNELS = 8;
	localparam int FADE_FRAME_BITS   = 24;

	// A register index that decodes to nothing; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	localparam int RANDOM_SAMPLES = 950;
	localparam int IDLE_GAP       = 4;
	localparam int TAIL_CYCLES    = 64;
	// The limit allows for the slowest, scaled items with the longest sender gap and
	// receiver stall, so it is several times the worst run.
	localparam int CYCLE_LIMIT    = 600000;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	// One line of the directed table: a register write or a sample, the latter
	// optionally carrying an expected result typed in by hand.
	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic signed [15:0]    sample;
		bit                    typed;
		logic signed [15:0]    want_sample;
		logic                  want_end;
	} stim_row_t;

	typedef struct {
		logic signed [15:0] sample;
		logic               chunk_end;
	} faded_t;

	logic clk;
	logic arst_n;

	cfl_in_if  sample_if ();
	cfl_out_if result_if ();
	cfl_cfg_if cfg_if ();

	chunk_linear_fade_ramp #(
		.MAX_CHANNELS     (FADE_MAX_CHANNELS),
		.FRAME_COUNT_BITS (FADE_FRAME_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_chan (sample_if),
		.result_chan (result_if),
		.cfg_chan    (cfg_if)
	);

	// The testbench's own copy of the register file and the chunk position.
	logic [RATE_W-1:0]          fade_rate;
	logic [CHAN_W-1:0]          fade_chans;
	logic [FADE_FRAME_BITS-1:0] fade_frames;
	longint unsigned            fade_pos;
	longint unsigned            fade_ramp;

	// Results still owed by the block, oldest first.
	faded_t faded_queue[$];
	stim_row_t directed_rows[$];

	int  fail_count;
	int  samples_sent;
	int  faded_count;
	int  chunk_ends;
	int  settings_used;
	int  cycle_count;
	int  burst_left;
	bit  steady_send;

	// The ramp is rate*5/1000 frames, but never more than half the chunk.
	function automatic void refresh_ramp();
		longint unsigned r;
		longint unsigned half;
		r = longint'(fade_rate) * 5 / 1000;
		half = longint'(fade_frames) / 2;
		fade_ramp = (r < half) ? r : half;
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_RATE: begin
				fade_rate = val[RATE_W-1:0];
			end
			REG_CHAN: begin
				fade_chans = val[CHAN_W-1:0];
			end
			REG_FRAMES: begin
				fade_frames = val[FADE_FRAME_BITS-1:0];
			end
			default: begin
				return;
			end
		endcase
		refresh_ramp();
	endfunction

	// Works out the faded sample and the end-of-chunk flag for one sample and moves
	// the position on. Scaling is sample*k/ramp rounded half away from zero.
	function automatic void fade_sample(input logic signed [15:0] s,
			output logic signed [15:0] y, output logic e, output bit scaled);
		longint unsigned ch;
		longint unsigned total;
		longint unsigned pos;
		longint unsigned last;
		longint unsigned span;
		longint unsigned k;
		longint unsigned mag;
		longint unsigned q;
		bit neg;
		bit hit;
		ch = (fade_chans > FADE_MAX_CHANNELS) ? FADE_MAX_CHANNELS : fade_chans;
		total = longint'(fade_frames) * ch;
		y = s;
		e = 1'b0;
		scaled = 1'b0;
		if (total == 0) begin
			// Empty chunk: nothing to count, the position is held at the start.
			fade_pos = 0;
		end else begin
			pos = fade_pos;
			last = total - 1;
			// The position also wraps when a smaller chunk left it beyond the end.
			if (pos >= last) begin
				e = 1'b1;
				fade_pos = 0;
			end else begin
				fade_pos = pos + 1;
			end
			if (pos <= last && fade_rate != 0 && fade_ramp != 0) begin
				span = fade_ramp * ch;
				hit = 1'b1;
				if (pos < span)
					k = pos / ch;
				else if (last - pos < span)
					k = (last - pos) / ch;
				else
					hit = 1'b0;
				if (hit) begin
					neg = (s < 0);
					mag = neg ? longint'(-longint'(s)) : longint'(s);
					q = (2 * mag * k + fade_ramp) / (2 * fade_ramp);
					y = neg ? 16'(-q) : 16'(q);
					scaled = 1'b1;
				end
			end
		end
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: return 16'sh7fff;
					1: return -16'sh8000;
					2: return -16'sh7fff;
					3: return 16'sh0001;
					4: return -16'sh0001;
					default: return 16'sh0000;
				endcase
			end
			1: return 16'($urandom_range(0, 7)) - 16'sd4;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		stim_row_t row;
		row = '{ROW_WRITE, idx, val, 16'sd0, 1'b0, 16'sd0, 1'b0};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_sample(input logic signed [15:0] s, input bit typed,
			input logic signed [15:0] want_s, input logic want_e);
		stim_row_t row;
		row = '{ROW_SAMPLE, REG_RATE, '0, s, typed, want_s, want_e};
		directed_rows.push_back(row);
	endfunction

	// Offers one sample and holds it until the block takes it. The expectation is
	// queued at the accepting edge. Bursts end with a random gap, none in steady phases,
	// or now and then with a pause until the block has handed back everything it owes.
	task automatic push_sample(input logic signed [15:0] s, input bit typed,
			input logic signed [15:0] want_s, input logic want_e);
		faded_t want;
		logic signed [15:0] y;
		logic e;
		bit sc;
		int gap;
		sample_if.valid <= 1'b1;
		sample_if.sample_in <= s;
		do @(posedge clk); while (!sample_if.ready);
		fade_sample(s, y, e, sc);
		want.sample = typed ? want_s : y;
		want.chunk_end = typed ? want_e : e;
		faded_queue.push_back(want);
		samples_sent++;
		if (sc)
			faded_count++;
		if (e)
			chunk_ends++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 11) == 0) begin
				sample_if.valid <= 1'b0;
				do @(posedge clk); while (faded_queue.size() != 0);
			end else if (!steady_send) begin
				gap = $urandom_range(1, 8);
				sample_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Registers are only written with the block idle: the input is lowered, every
	// owed result is collected and an IDLE_GAP wait passes before the write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		sample_if.valid <= 1'b0;
		do @(posedge clk); while (faded_queue.size() != 0);
		repeat (IDLE_GAP) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		apply_setting(idx, val);
		settings_used++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		sample_if.valid = 1'b0;
		sample_if.sample_in = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		result_if.ready = 1'b0;
	end

	// Receiver back-pressure. From time to time a new pattern is picked: always
	// ready, coin-toss ready, sparse periodic readiness, or long stalls.
	int stall_tick;
	int stall_mode;
	always @(posedge clk) begin
		if (stall_tick % 48 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: result_if.ready <= 1'b1;
			1: result_if.ready <= 1'($urandom_range(0, 1));
			2: result_if.ready <= (stall_tick % 5 == 0);
			default: result_if.ready <= (stall_tick % 16 >= 12);
		endcase
		stall_tick++;
	end

	// Each accepted result is checked against the oldest expectation.
	always @(posedge clk) begin
		faded_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (faded_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual sample_out %0d chunk_end %0b",
					$time, result_if.sample_out, result_if.chunk_end);
				fail_count++;
			end else begin
				want = faded_queue.pop_front();
				if (result_if.sample_out !== want.sample) begin
					$display("%0t: sample_out mismatch, expected %0d, actual %0d",
						$time, want.sample, result_if.sample_out);
					fail_count++;
				end
				if (result_if.chunk_end !== want.chunk_end) begin
					$display("%0t: chunk_end mismatch, expected %0b, actual %0b",
						$time, want.chunk_end, result_if.chunk_end);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, faded_queue.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int n;
		int random_sent;
		int pick;
		longint unsigned ch;
		longint unsigned total;
		bit wrote;

		fade_rate = '0;
		fade_chans = CHAN_W'(1);
		fade_frames = '0;
		fade_pos = 0;
		fade_ramp = 0;
		fail_count = 0;
		samples_sent = 0;
		faded_count = 0;
		chunk_ends = 0;
		settings_used = 0;
		cycle_count = 0;
		stall_tick = 0;
		stall_mode = 0;
		burst_left = 4;
		steady_send = 1'b0;

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Straight out of reset the chunk is empty, so samples pass untouched and
		// never flag the end of a chunk.
		add_sample(16'sh7fff, 1'b1, 16'sh7fff, 1'b0);
		add_sample(-16'sh8000, 1'b1, -16'sh8000, 1'b0);

		// Four single-channel frames with a two-frame ramp: gains 0, 1/2, 1/2, 0.
		// The full-scale rows show exact halving and rounding half away from zero.
		add_write(REG_FRAMES, 32'd4);
		add_write(REG_CHAN, 32'd1);
		add_write(REG_RATE, 32'd400);
		add_sample(-16'sh8000, 1'b1, 16'sd0, 1'b0);
		add_sample(-16'sh8000, 1'b1, -16'sd16384, 1'b0);
		add_sample(16'sh7fff, 1'b1, 16'sd16384, 1'b0);
		add_sample(16'sh7fff, 1'b1, 16'sd0, 1'b1);
		add_sample(16'sd1, 1'b1, 16'sd0, 1'b0);
		add_sample(-16'sd1, 1'b1, -16'sd1, 1'b0);
		add_sample(16'sd1, 1'b1, 16'sd1, 1'b0);
		add_sample(-16'sd5, 1'b1, 16'sd0, 1'b1);

		// A zero rate bypasses the scaling while the chunk count carries on.
		add_write(REG_RATE, 32'd0);
		add_sample(16'sh1234, 1'b0, 16'sd0, 1'b0);
		add_sample(-16'sh0800, 1'b0, 16'sd0, 1'b0);
		add_sample(16'sh4321, 1'b0, 16'sd0, 1'b0);
		add_sample(-16'sh7000, 1'b0, 16'sd0, 1'b0);

		// No channels makes the chunk empty.
		add_write(REG_CHAN, 32'd0);
		add_sample(16'sh2222, 1'b0, 16'sd0, 1'b0);
		add_sample(-16'sh2222, 1'b0, 16'sd0, 1'b0);

		// More channels than the block holds are treated as the maximum; the
		// write to the unused index must change nothing.
		add_write(REG_CHAN, 32'd12);
		add_write(REG_RATE, 32'd400);
		add_write(REG_NONE, 32'hffff_ffff);
		add_sample(16'sh3fff, 1'b0, 16'sd0, 1'b0);
		add_sample(-16'sh3fff, 1'b0, 16'sd0, 1'b0);
		add_sample(16'sh0101, 1'b0, 16'sd0, 1'b0);

		// A rate too low to give a whole frame of ramp is also a bypass.
		add_write(REG_RATE, 32'd199);
		add_sample(16'sh5a5a, 1'b0, 16'sd0, 1'b0);

		// Shrinking the chunk beneath the current position: the next sample passes
		// unchanged, closes the chunk and sends the position back to the start.
		add_write(REG_CHAN, 32'd1);
		add_write(REG_FRAMES, 32'd8);
		add_write(REG_RATE, 32'd400);
		add_sample(16'sh6000, 1'b0, 16'sd0, 1'b0);
		add_write(REG_FRAMES, 32'd2);
		add_sample(16'sh6000, 1'b1, 16'sh6000, 1'b1);
		add_sample(16'sh6000, 1'b0, 16'sd0, 1'b0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			else
				push_sample(directed_rows[i].sample, directed_rows[i].typed,
					directed_rows[i].want_sample, directed_rows[i].want_end);
		end

		// Random phases. Each changes some registers, then mostly runs the chunk to
		// completion (a few times over when it is short) with random sample values.
		// Writes never clear the position, so shrunken chunks crop up on their own.
		random_sent = 0;
		while (random_sent < RANDOM_SAMPLES) begin
			wrote = 1'b0;
			while (!wrote) begin
				if ($urandom_range(0, 1)) begin
					pick = $urandom_range(0, 19);
					if (pick < 14)
						write_reg(REG_RATE, $urandom_range(200, 4200));
					else if (pick < 16)
						write_reg(REG_RATE, $urandom_range(0, 384000));
					else if (pick < 18)
						write_reg(REG_RATE, 384000);
					else
						write_reg(REG_RATE, $urandom_range(0, 199));
					wrote = 1'b1;
				end
				if ($urandom_range(0, 1)) begin
					pick = $urandom_range(0, 9);
					if (pick < 8)
						write_reg(REG_CHAN, $urandom_range(1, 8));
					else if (pick < 9)
						write_reg(REG_CHAN, 0);
					else
						write_reg(REG_CHAN, $urandom_range(9, 15));
					wrote = 1'b1;
				end
				if ($urandom_range(0, 1)) begin
					pick = $urandom_range(0, 19);
					if (pick < 15)
						write_reg(REG_FRAMES, $urandom_range(0, 40));
					else if (pick < 17)
						write_reg(REG_FRAMES, $urandom_range(41, 600));
					else if (pick < 19)
						write_reg(REG_FRAMES, $urandom_range(0, 32'h00ff_ffff));
					else
						write_reg(REG_FRAMES, 32'h00ff_ffff);
					wrote = 1'b1;
				end
				if ($urandom_range(0, 15) == 0)
					write_reg(REG_NONE, $urandom);
			end

			ch = (fade_chans > FADE_MAX_CHANNELS) ? FADE_MAX_CHANNELS : fade_chans;
			total = longint'(fade_frames) * ch;
			if (total == 0)
				n = $urandom_range(2, 6);
			else if (total <= 200) begin
				n = (fade_pos >= total) ? 1 : int'(total - fade_pos);
				n += $urandom_range(0, 2) * int'(total) + $urandom_range(0, 3);
				if (n > 250)
					n = 250;
			end else
				n = $urandom_range(10, 60);
			// The last phase stops at the planned number of samples.
			if (n > RANDOM_SAMPLES - random_sent)
				n = RANDOM_SAMPLES - random_sent;

			// Some phases run without the random sender gaps.
			steady_send = ($urandom_range(0, 3) == 0);
			repeat (n) begin
				push_sample(pick_sample(), 1'b0, 16'sd0, 1'b0);
				random_sent++;
			end
		end

		sample_if.valid <= 1'b0;
		do @(posedge clk); while (faded_queue.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d samples, %0d of them scaled on a ramp, %0d chunk ends,",
			samples_sent, faded_count, chunk_ends);
		$display("across %0d register writes; %0d check failures.", settings_used, fail_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/cfl_pkg.sv
src/cfl_stream_if.sv
src/cfl_divider.sv
src/cfl_seq.sv
src/chunk_linear_fade_ramp.sv
tb/chunk_linear_fade_ramp_test.sv
